// ===== src/sstbl_pkg.sv =====
// Shared types, sizes and codes for the source-specific route table.
package sstbl_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int OCC_W = 7;
    localparam int IN_W = 336;
    localparam int OUT_W = 72;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    typedef enum logic [2:0] {
        ST_UNCHANGED = 3'd0,
        ST_INSERTED = 3'd1,
        ST_LOWERED = 3'd2,
        ST_FULL = 3'd3,
        ST_REMOVED = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_FOUND = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [15:0] lens;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic [15:0] metric;
        logic [31:0] iface;
        logic [7:0]  proto;
    } entry_t;

    typedef struct packed {
        logic             active;
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [15:0]      metric;
        logic [31:0]      iface;
        logic [7:0]       proto;
    } token_t;

    typedef struct packed {
        logic             ins;
        logic             upd;
        logic             del;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] last;
        entry_t           entry;
    } wr_t;

endpackage

// ===== src/sstbl_cell.sv =====
// One table slot: holds an entry, matches the passing search token, takes writes and shifts.
module sstbl_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sstbl_pkg::IDX_W-1:0] cell_idx,
    input  logic [sstbl_pkg::CNT_W-1:0] count,
    input  sstbl_pkg::key_t             key,
    input  sstbl_pkg::token_t           tok_in,
    output sstbl_pkg::token_t           tok_out,
    input  sstbl_pkg::wr_t              wr,
    input  sstbl_pkg::entry_t           nb_entry,
    output sstbl_pkg::entry_t           entry
);
    import sstbl_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    token_t tok_reg;
    token_t tok_next;
    logic   valid;
    logic   match;

    assign valid = ({{CNT_W{1'b0}}, cell_idx}) < ({{IDX_W{1'b0}}, count});
    assign match = valid && (entry_reg.key == key);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && !tok_in.hit && match)
        begin
            tok_next.hit = 1'b1;
            tok_next.idx = cell_idx;
            tok_next.metric = entry_reg.metric;
            tok_next.iface = entry_reg.iface;
            tok_next.proto = entry_reg.proto;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (wr.ins && wr.idx == cell_idx)
        begin
            entry_next = wr.entry;
        end
        if (wr.upd && wr.idx == cell_idx)
        begin
            entry_next.metric = wr.entry.metric;
        end
        if (wr.del && cell_idx >= wr.idx && cell_idx < wr.last)
        begin
            entry_next = nb_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign tok_out = tok_reg;
    assign entry = entry_reg;

endmodule

// ===== src/source_specific_route_table_core.sv =====
// Top level: request control, chain of table cells and result register.
//
//  channel  | dir | handshake                        | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready    | action and route key, metric, iface, proto
//  m_axis   | out | m_axis_tvalid / m_axis_tready    | status, stored fields, occupancy
//
// In each transaction a search token walks the
// cell chain one slot per cycle, then the apply step applies the change and loads the result.
// The next transaction is taken while a result waits; the apply step holds until the
// result register is free. Reset clears the entry count; slot contents stay unknown.
module source_specific_route_table_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // action, dest_prefix_high, dest_prefix_low, dest_prefix_len, source_prefix_high,
    // source_prefix_low, source_prefix_len, metric, interface_index, protocol, zero pad
    input  logic [sstbl_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // status, result_metric, result_interface, result_protocol, occupancy, zero pad
    output logic [sstbl_pkg::OUT_W-1:0] m_axis_tdata
);
    import sstbl_pkg::*;

    state_t state_reg;
    state_t state_next;

    key_t        key_reg;
    logic [1:0]  action_reg;
    logic [15:0] metric_reg;
    logic [31:0] iface_reg;
    logic [7:0]  proto_reg;
    logic        launch_reg;
    token_t      res_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] out_data_next;

    logic    accept;
    logic    tok_done;
    logic    apply;
    wr_t     wr;
    status_t status;
    logic [15:0] rm;
    logic [31:0] ri;
    logic [7:0]  rp;

    token_t tok [TABLE_DEPTH+1];
    entry_t ent [TABLE_DEPTH];
    entry_t nb  [TABLE_DEPTH];

    assign accept = s_axis_tvalid && s_axis_tready;
    assign tok_done = tok[TABLE_DEPTH].active;

    always_comb
    begin
        tok[0] = '0;
        tok[0].active = launch_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            if (gi < TABLE_DEPTH - 1)
            begin : g_nb
                assign nb[gi] = ent[gi+1];
            end
            else
            begin : g_end
                assign nb[gi] = ent[gi];
            end
            sstbl_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IDX_W'(gi)),
                .count    (count_reg),
                .key      (key_reg),
                .tok_in   (tok[gi]),
                .tok_out  (tok[gi+1]),
                .wr       (wr),
                .nb_entry (nb[gi]),
                .entry    (ent[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tok_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (apply)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        apply = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);
    end

    always_comb
    begin
        status = ST_UNCHANGED;
        rm = '0;
        ri = '0;
        rp = '0;
        count_next = count_reg;
        wr = '0;
        wr.entry.key = key_reg;
        wr.entry.metric = metric_reg;
        wr.entry.iface = iface_reg;
        wr.entry.proto = proto_reg;
        wr.last = IDX_W'(count_reg - CNT_W'(1));
        case (action_reg)
            ACT_ADD:
            begin
                if (res_reg.hit)
                begin
                    ri = res_reg.iface;
                    rp = res_reg.proto;
                    if (metric_reg < res_reg.metric)
                    begin
                        status = ST_LOWERED;
                        rm = metric_reg;
                        wr.upd = apply;
                        wr.idx = res_reg.idx;
                    end
                    else
                    begin
                        rm = res_reg.metric;
                    end
                end
                else if (count_reg >= CNT_W'(TABLE_DEPTH))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status = ST_INSERTED;
                    rm = metric_reg;
                    ri = iface_reg;
                    rp = proto_reg;
                    wr.ins = apply;
                    wr.idx = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_DELETE:
            begin
                if (res_reg.hit)
                begin
                    status = ST_REMOVED;
                    rm = res_reg.metric;
                    ri = res_reg.iface;
                    rp = res_reg.proto;
                    wr.del = apply;
                    wr.idx = res_reg.idx;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            ACT_LOOKUP:
            begin
                if (res_reg.hit)
                begin
                    status = ST_FOUND;
                    rm = res_reg.metric;
                    ri = res_reg.iface;
                    rp = res_reg.proto;
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status = ST_UNCHANGED;
            end
        endcase
        out_data_next = {6'd0, OCC_W'(count_next), rp, ri, rm, status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            launch_reg <= accept;
            if (apply)
            begin
                count_reg <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= s_axis_tdata[1:0];
            key_reg.dest_high <= s_axis_tdata[65:2];
            key_reg.dest_low <= s_axis_tdata[129:66];
            key_reg.source_high <= s_axis_tdata[201:138];
            key_reg.source_low <= s_axis_tdata[265:202];
            key_reg.lens <= {s_axis_tdata[137:130], s_axis_tdata[273:266]};
            metric_reg <= s_axis_tdata[289:274];
            iface_reg <= s_axis_tdata[321:290];
            proto_reg <= s_axis_tdata[329:322];
        end
        if (state_reg == S_SCAN && tok_done)
        begin
            res_reg <= tok[TABLE_DEPTH];
        end
        if (apply)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

endmodule

// ===== tb/tb_source_specific_route_table_core.sv =====
// Testbench for the source-specific route table: directed table plus random route traffic.
`timescale 1ns / 1ps

module tb_source_specific_route_table_core;
    import sstbl_pkg::*;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [7:0]  dest_len;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [7:0]  source_len;
        logic [15:0] metric;
        logic [31:0] iface;
        logic [7:0]  proto;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] metric;
        logic [31:0] iface;
        logic [7:0]  proto;
        logic [6:0]  occupancy;
    } reply_t;

    typedef struct {
        request_t req;
        logic     has_reply;
        reply_t   reply;
    } directed_row_t;

    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam int         KEY_POOL = 80;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;

    entry_t            route_shadow[TABLE_DEPTH];
    int                route_count;
    reply_t            pending_replies[$];
    request_t          key_pool[KEY_POOL];
    directed_row_t     directed_rows[$];
    int                mismatch_count;
    int                reply_count;
    int                sent_count;
    int                full_count;
    int                lowered_count;
    int                removed_count;
    logic              hold_off;
    logic              hold_off_done;

    source_specific_route_table_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [IN_W-1:0] pack_request(request_t r);
        logic [IN_W-1:0] v;
        v = '0;
        v[1:0]     = r.action;
        v[65:2]    = r.dest_high;
        v[129:66]  = r.dest_low;
        v[137:130] = r.dest_len;
        v[201:138] = r.source_high;
        v[265:202] = r.source_low;
        v[273:266] = r.source_len;
        v[289:274] = r.metric;
        v[321:290] = r.iface;
        v[329:322] = r.proto;
        return v;
    endfunction

    function automatic reply_t unpack_reply(logic [OUT_W-1:0] v);
        reply_t r;
        r.status    = v[2:0];
        r.metric    = v[18:3];
        r.iface     = v[50:19];
        r.proto     = v[58:51];
        r.occupancy = v[65:59];
        return r;
    endfunction

    function automatic key_t request_key(request_t r);
        key_t k;
        k.dest_high   = r.dest_high;
        k.dest_low    = r.dest_low;
        k.source_high = r.source_high;
        k.source_low  = r.source_low;
        k.lens        = {r.dest_len, r.source_len};
        return k;
    endfunction

    function automatic reply_t apply_route_change(request_t r);
        reply_t o;
        key_t   k;
        int     hit;
        k = request_key(r);
        o = '0;
        hit = -1;
        for (int i = 0; i < route_count; i++)
        begin
            if (hit < 0 && route_shadow[i].key == k)
                hit = i;
        end
        case (r.action)
            ACT_ADD:
            begin
                if (hit >= 0)
                begin
                    if (r.metric < route_shadow[hit].metric)
                    begin
                        route_shadow[hit].metric = r.metric;
                        o.status = ST_LOWERED;
                    end
                    else
                        o.status = ST_UNCHANGED;
                    o.metric = route_shadow[hit].metric;
                    o.iface  = route_shadow[hit].iface;
                    o.proto  = route_shadow[hit].proto;
                end
                else if (route_count >= TABLE_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    route_shadow[route_count].key    = k;
                    route_shadow[route_count].metric = r.metric;
                    route_shadow[route_count].iface  = r.iface;
                    route_shadow[route_count].proto  = r.proto;
                    route_count++;
                    o.status = ST_INSERTED;
                    o.metric = r.metric;
                    o.iface  = r.iface;
                    o.proto  = r.proto;
                end
            end
            ACT_DELETE:
            begin
                if (hit >= 0)
                begin
                    o.status = ST_REMOVED;
                    o.metric = route_shadow[hit].metric;
                    o.iface  = route_shadow[hit].iface;
                    o.proto  = route_shadow[hit].proto;
                    route_shadow[hit] = route_shadow[route_count - 1];
                    route_count--;
                end
                else
                    o.status = ST_NOT_FOUND;
            end
            ACT_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    o.status = ST_FOUND;
                    o.metric = route_shadow[hit].metric;
                    o.iface  = route_shadow[hit].iface;
                    o.proto  = route_shadow[hit].proto;
                end
                else
                    o.status = ST_NOT_FOUND;
            end
            default:
                o.status = ST_UNCHANGED;
        endcase
        o.occupancy = route_count[6:0];
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [7:0] random_len();
        return ($urandom_range(7) == 0) ? 8'($urandom()) : 8'($urandom_range(128));
    endfunction

    function automatic request_t random_key_request(logic [1:0] act);
        request_t r;
        r = key_pool[$urandom_range(KEY_POOL - 1)];
        r.action = act;
        r.metric = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom());
        r.iface  = $urandom();
        r.proto  = 8'($urandom());
        return r;
    endfunction

    function automatic request_t make_request(logic [1:0] act, logic [63:0] fill,
                                              logic [7:0] len, logic [15:0] met);
        request_t r;
        r.action      = act;
        r.dest_high   = fill;
        r.dest_low    = fill;
        r.dest_len    = len;
        r.source_high = fill;
        r.source_low  = fill;
        r.source_len  = len;
        r.metric      = met;
        r.iface       = {fill[31:0]};
        r.proto       = fill[7:0];
        return r;
    endfunction

    function automatic reply_t make_reply(logic [2:0] st, logic [15:0] met, logic [31:0] ifc,
                                          logic [7:0] pr, logic [6:0] occ);
        reply_t o;
        o.status    = st;
        o.metric    = met;
        o.iface     = ifc;
        o.proto     = pr;
        o.occupancy = occ;
        return o;
    endfunction

    task automatic add_row(request_t r, logic known, reply_t o);
        directed_row_t d;
        d.req       = r;
        d.has_reply = known;
        d.reply     = o;
        directed_rows.push_back(d);
    endtask

    task automatic send_request(request_t r, logic known, reply_t o);
        reply_t predicted;
        predicted = apply_route_change(r);
        if (known && predicted !== o)
            $display("directed row disagrees with predictor: %h vs %h", o, predicted);
        pending_replies.push_back(known ? o : predicted);
        if (predicted.status == ST_FULL)
            full_count++;
        if (predicted.status == ST_LOWERED)
            lowered_count++;
        if (predicted.status == ST_REMOVED)
            removed_count++;
        s_axis_tdata  <= pack_request(r);
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
    endtask

    task automatic idle_sender(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = unpack_reply(m_axis_tdata);
            reply_count++;
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: %h", got);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected st=%0d m=%h i=%h p=%h occ=%0d,",
                                  " got st=%0d m=%h i=%h p=%h occ=%0d"},
                                 want.status, want.metric, want.iface, want.proto,
                                 want.occupancy, got.status, got.metric, got.iface,
                                 got.proto, got.occupancy);
                end
            end
        end
    end

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        hold_off_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && !hold_off_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off_done = 1'b1;
            end
            stall = $urandom_range(9);
            if (stall < 3)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(stall * 40)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 150)) @(posedge clk);
        end
    end

    initial
    begin
        #100ms;
        $display("** source_specific_route_table_core: FAILED **");
        $finish;
    end

    initial
    begin
        request_t r;
        int       burst;
        int       pick;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        hold_off       = 1'b0;
        route_count    = 0;
        mismatch_count = 0;
        reply_count    = 0;
        sent_count     = 0;
        full_count     = 0;
        lowered_count  = 0;
        removed_count  = 0;
        for (int i = 0; i < KEY_POOL; i++)
        begin
            key_pool[i].dest_high   = rand64();
            key_pool[i].dest_low    = rand64();
            key_pool[i].dest_len    = random_len();
            key_pool[i].source_high = rand64();
            key_pool[i].source_low  = rand64();
            key_pool[i].source_len  = random_len();
            if (i % 5 == 0)
                key_pool[i].source_high = key_pool[0].source_high;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(make_request(ACT_LOOKUP, '0, 8'd0, 16'd0), 1'b1,
                make_reply(ST_NOT_FOUND, 16'd0, 32'd0, 8'd0, 7'd0));
        add_row(make_request(ACT_DELETE, '0, 8'd0, 16'd0), 1'b1,
                make_reply(ST_NOT_FOUND, 16'd0, 32'd0, 8'd0, 7'd0));
        add_row(make_request(ACT_ADD, '0, 8'd0, 16'd0), 1'b1,
                make_reply(ST_INSERTED, 16'd0, 32'd0, 8'd0, 7'd1));
        add_row(make_request(ACT_ADD, '1, 8'd128, 16'hFFFF), 1'b1,
                make_reply(ST_INSERTED, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 7'd2));
        add_row(make_request(ACT_ADD, '1, 8'd255, 16'h1234), 1'b0, '0);
        add_row(make_request(ACT_ADD, '1, 8'd128, 16'hFFFF), 1'b1,
                make_reply(ST_UNCHANGED, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 7'd3));
        add_row(make_request(ACT_ADD, '1, 8'd128, 16'h0010), 1'b1,
                make_reply(ST_LOWERED, 16'h0010, 32'hFFFFFFFF, 8'hFF, 7'd3));
        add_row(make_request(ACT_LOOKUP, '1, 8'd128, 16'd0), 1'b1,
                make_reply(ST_FOUND, 16'h0010, 32'hFFFFFFFF, 8'hFF, 7'd3));
        add_row(make_request(ACT_IGNORED, '1, 8'd128, 16'd0), 1'b1,
                make_reply(ST_UNCHANGED, 16'd0, 32'd0, 8'd0, 7'd3));
        add_row(make_request(ACT_LOOKUP, 64'h5555_5555_5555_5555, 8'd64, 16'd0), 1'b0, '0);
        add_row(make_request(ACT_DELETE, '0, 8'd0, 16'd0), 1'b1,
                make_reply(ST_REMOVED, 16'd0, 32'd0, 8'd0, 7'd2));
        add_row(make_request(ACT_LOOKUP, '1, 8'd255, 16'd0), 1'b0, '0);
        add_row(make_request(ACT_DELETE, '1, 8'd128, 16'd0), 1'b0, '0);
        add_row(make_request(ACT_DELETE, '1, 8'd255, 16'd0), 1'b1,
                make_reply(ST_REMOVED, 16'h1234, 32'hFFFFFFFF, 8'hFF, 7'd0));
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].has_reply, directed_rows[i].reply);
        wait_drained();

        for (int i = 0; i < TABLE_DEPTH + 2; i++)
        begin
            r = make_request(ACT_ADD, {32'($urandom()), 32'(i)}, 8'(i), 16'($urandom()));
            if (i == TABLE_DEPTH / 2)
                hold_off = 1'b1;
            send_request(r, 1'b0, '0);
        end
        for (int i = 0; i < 12; i++)
            send_request(random_key_request(ACT_DELETE), 1'b0, '0);
        wait_drained();

        while (sent_count < 470)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    r = random_key_request(ACT_ADD);
                else if (pick < 70)
                    r = random_key_request(ACT_DELETE);
                else if (pick < 95)
                    r = random_key_request(ACT_LOOKUP);
                else
                begin
                    r = random_key_request(ACT_IGNORED);
                    r.dest_high = rand64();
                end
                send_request(r, 1'b0, '0);
            end
            if ($urandom_range(3) == 0)
                idle_sender($urandom_range(1, 200));
        end
        wait_drained();
        repeat (TABLE_DEPTH + 10) @(posedge clk);

        $display("Sent %0d route transactions, checked %0d replies",
                 sent_count, reply_count);
        $display("(%0d table full, %0d lowered, %0d removed).",
                 full_count, lowered_count, removed_count);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("** source_specific_route_table_core: PASSED **");
        else
            $display("** source_specific_route_table_core: FAILED **");
        $finish;
    end
endmodule
